[sv/pklim_pkg.sv]
// ----------------------------------------------------------------------------
// pklim_pkg
// Shared widths, constants, register indexes and controller/datapath
// interface types for the peak limiter with hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pklim_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int THRESH_W = 23;
    localparam int COEFF_W  = 17;
    localparam int HOLD_W   = 16;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 2;

    // Operands of the shared multiplier and its registered product.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // Quotient bits produced by the restoring divider, one per cycle.
    localparam int DIV_STEPS = 23;
    localparam int DIV_CNT_W = 5;

    localparam logic [GAIN_W-1:0]   UNITY_GAIN      = 24'd8388608;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 23'd8388607;
    localparam logic [COEFF_W-1:0]  ATTACK_RST      = 17'd65536;
    localparam logic [COEFF_W-1:0]  RELEASE_RST     = 17'd655;
    localparam logic [HOLD_W-1:0]   HOLD_RST        = 16'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd3;

    typedef struct packed {
        logic load;      // capture the sample and seed the divider
        logic div_step;  // one restoring division step
        logic mul_coef;  // multiply gain error by the chosen coefficient
        logic update;    // update gain and hold counter
        logic mul_out;   // multiply sample by the new gain
        logic out_load;  // write the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;  // level exceeds threshold
    } dp_status_t;

endpackage : pklim_pkg

`default_nettype wire

[sv/pklim_ctrl.sv]
// ----------------------------------------------------------------------------
// pklim_ctrl
// Sequencer for the peak limiter: accepts a request, runs the divider, the
// coefficient multiply, the gain update and the output multiply, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pklim_ctrl
    import pklim_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL1,
        ST_UPD,
        ST_MUL2,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Without an overload the target is unity and no quotient is needed.
                cmd.div_step = status.need_div;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (!status.need_div || cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_coef = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_out = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten while a result waits");

    a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("accepted request did not start the divider");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider ran past its last quotient bit");

endmodule : pklim_ctrl

`default_nettype wire

[sv/pklim_dp.sv]
// ----------------------------------------------------------------------------
// pklim_dp
// Datapath of the peak limiter: configuration registers, level and
// restoring divider, shared 25x25 multiplier, gain and hold state, and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pklim_dp
    import pklim_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [SAMPLE_W-1:0]   sample,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic [SAMPLE_W-1:0]        out_sample,
    output logic [GAIN_W-1:0]          applied_gain
);

    logic [THRESH_W-1:0] threshold_reg;
    logic [COEFF_W-1:0]  attack_reg;
    logic [COEFF_W-1:0]  release_reg;
    logic [HOLD_W-1:0]   hold_samples_reg;

    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;

    logic [SAMPLE_W-1:0] smp_reg;
    logic [SAMPLE_W-1:0] level_reg;
    logic [SAMPLE_W:0]   rem_reg;
    logic [THRESH_W-1:0] quo_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [GAIN_W-1:0]   applied_gain_reg;

    logic [SAMPLE_W-1:0] level_in;
    logic [SAMPLE_W:0]   rem_shift;
    logic                rem_ge;
    logic [GAIN_W-1:0]   target;
    logic                attack;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [MUL_W-1:0]  diff;
    logic [COEFF_W-1:0]       coeff;
    logic signed [26:0]  step;
    logic signed [26:0]  gsum;
    logic signed [26:0]  target_ext;

    // Two's complement negation in 24 bits maps the most negative sample to
    // 8388608, which is its magnitude read as unsigned.
    assign level_in = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

    assign status.need_div = (level_reg > {1'b0, threshold_reg});
    assign target = status.need_div ? {1'b0, quo_reg} : UNITY_GAIN;
    assign attack = (gain_reg > target);

    assign rem_shift = {rem_reg[SAMPLE_W-1:0], 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, level_reg});

    assign diff  = $signed({1'b0, target}) - $signed({1'b0, gain_reg});
    assign coeff = attack ? attack_reg : release_reg;

    assign mul_a   = cmd.mul_out ? $signed({smp_reg[SAMPLE_W-1], smp_reg}) : diff;
    assign mul_b   = cmd.mul_out ? $signed({1'b0, gain_reg})
                                 : $signed({{(MUL_W-COEFF_W){1'b0}}, coeff});
    assign product = mul_a * mul_b;

    // The coefficient product fits in 43 signed bits, so these bits are the
    // floor of the product over 65536.
    assign step       = prod_reg[42:16];
    assign gsum       = $signed({3'b000, gain_reg}) + step;
    assign target_ext = $signed({3'b000, target});

    always_comb
    begin
        gain_next = gain_reg;
        hold_next = hold_reg;
        if (cmd.update)
        begin
            priority if (attack)
            begin
                gain_next = (gsum < target_ext) ? target : gsum[GAIN_W-1:0];
                hold_next = hold_samples_reg;
            end
            else if (hold_reg != '0)
            begin
                hold_next = hold_reg - HOLD_W'(1);
            end
            else
            begin
                gain_next = (gsum > target_ext) ? target : gsum[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            attack_reg       <= ATTACK_RST;
            release_reg      <= RELEASE_RST;
            hold_samples_reg <= HOLD_RST;
            gain_reg         <= UNITY_GAIN;
            hold_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: threshold_reg    <= cfg_data[THRESH_W-1:0];
                    CFG_ATTACK:    attack_reg       <= cfg_data[COEFF_W-1:0];
                    CFG_RELEASE:   release_reg      <= cfg_data[COEFF_W-1:0];
                    CFG_HOLD:      hold_samples_reg <= cfg_data[HOLD_W-1:0];
                    default:       ;
                endcase
            end
            gain_reg <= gain_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg   <= sample;
            level_reg <= level_in;
            rem_reg   <= {2'b00, threshold_reg};
            quo_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? (rem_shift - {1'b0, level_reg}) : rem_shift;
            quo_reg <= {quo_reg[THRESH_W-2:0], rem_ge};
        end
        if (cmd.mul_coef || cmd.mul_out)
        begin
            prod_reg <= product;
        end
        if (cmd.out_load)
        begin
            out_sample_reg   <= prod_reg[46:23];
            applied_gain_reg <= gain_reg;
        end
    end

    assign out_sample   = out_sample_reg;
    assign applied_gain = applied_gain_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("gain left the range zero to unity");

    a_hold_keeps_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !attack && hold_reg != '0) |=> (gain_reg == $past(gain_reg)))
        else $error("gain moved while the hold counter was running");

endmodule : pklim_dp

`default_nettype wire

[sv/peak_limiter_with_hold_core.sv]
// ----------------------------------------------------------------------------
// peak_limiter_with_hold_core
// Sample-by-sample peak limiter with attack, release and hold.
// ----------------------------------------------------------------------------
// Each request carries one signed Q1.23 sample and produces one result: the
// limited sample and the Q1.23 gain applied to it. Only a sample whose
// magnitude exceeds the threshold runs the 23-step restoring divider that
// forms threshold over level. The coefficient step and the output product
// share one 25x25 multiplier. A finished result sits in an output register,
// so the next request is taken while it waits. Registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peak_limiter_with_hold_core
    import pklim_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SAMPLE_W-1:0]        out_sample,
    output logic [GAIN_W-1:0]          applied_gain
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pklim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pklim_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .out_sample   (out_sample),
        .applied_gain (applied_gain)
    );

endmodule : peak_limiter_with_hold_core

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peak limiter with attack, release and hold.
// ----------------------------------------------------------------------------
// Samples go in over a valid/ready request channel, and each accepted request
// is run through a bit-true gain tracker kept inside the bench. Each limited
// sample that comes back is compared field by field with the oldest
// prediction. A short directed part covers full-scale and zero samples,
// threshold and coefficient corners and a maximal hold. Random envelopes
// follow, built from loud bursts and quiet tails so that attack, hold and
// release all run, and then free-running random samples. The sender idles in
// random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pklim_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int FULL_SCALE     = 8388608;

    typedef enum int { SMP_LOUD, SMP_QUIET, SMP_ANY } sample_kind_t;
    typedef enum int { RX_ALWAYS, RX_COIN, RX_BURSTY } rx_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_sample;
        logic [GAIN_W-1:0]   gain;
    } limit_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [SAMPLE_W-1:0]  out_sample;
    logic [GAIN_W-1:0]    applied_gain;

    // Bench copy of the limiter registers and gain state.
    logic [THRESH_W-1:0]  thr_cfg;
    logic [COEFF_W-1:0]   atk_cfg;
    logic [COEFF_W-1:0]   rel_cfg;
    logic [HOLD_W-1:0]    hold_cfg;
    logic [GAIN_W-1:0]    gain_model;
    logic [HOLD_W-1:0]    hold_model;

    limit_result_t limited_q[$];

    int err_cnt      = 0;
    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int setting_cnt  = 0;
    int attack_cnt   = 0;
    int holding_cnt  = 0;
    int release_cnt  = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit no_idle      = 1'b0;

    peak_limiter_with_hold_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sample   (out_sample),
        .applied_gain (applied_gain)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the gain tracker by one sample and returns the limited result.
    function automatic limit_result_t limiter_predict(logic [SAMPLE_W-1:0] smp_bits);
        longint smp;
        longint level;
        longint tgt;
        longint g;
        longint prod;
        limit_result_t r;
        smp   = longint'(signed'(smp_bits));
        level = (smp < 0) ? -smp : smp;
        if (level > longint'(thr_cfg))
            tgt = (longint'(thr_cfg) << 23) / level;
        else
            tgt = longint'(UNITY_GAIN);
        g = longint'(gain_model);
        if (g > tgt)
        begin
            g = g + (((tgt - g) * longint'(atk_cfg)) >>> 16);
            if (g < tgt)
                g = tgt;
            hold_model = hold_cfg;
            attack_cnt++;
        end
        else if (hold_model != '0)
        begin
            hold_model = hold_model - 1'b1;
            holding_cnt++;
        end
        else
        begin
            g = g + (((tgt - g) * longint'(rel_cfg)) >>> 16);
            if (g > tgt)
                g = tgt;
            release_cnt++;
        end
        gain_model   = g[GAIN_W-1:0];
        prod         = (smp * g) >>> 23;
        r.out_sample = prod[SAMPLE_W-1:0];
        r.gain       = g[GAIN_W-1:0];
        return r;
    endfunction

    // Draws a sample above the threshold, at or below it, or with any bits.
    function automatic logic [SAMPLE_W-1:0] make_sample(sample_kind_t kind);
        int unsigned lvl;
        logic [SAMPLE_W-1:0] s;
        if (kind == SMP_ANY)
        begin
            case ($urandom_range(0, 7))
                0:       return 24'h800000;
                1:       return 24'h7FFFFF;
                2:       return '0;
                default: return SAMPLE_W'($urandom);
            endcase
        end
        if (kind == SMP_LOUD)
            lvl = $urandom_range(FULL_SCALE, thr_cfg + 1);
        else
            lvl = $urandom_range(thr_cfg, 0);
        // A level of full scale wraps to the most negative code either way.
        s = lvl[SAMPLE_W-1:0];
        if ($urandom_range(0, 1))
            s = -s;
        return s;
    endfunction

    task automatic wait_for_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (limited_q.size() != 0)
            @(posedge clk);
    endtask

    // Sends one request, idling first when the current burst has run out.
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_idle ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= x;
        do
            @(posedge clk);
        while (!in_ready);
        limited_q.push_back(limiter_predict(x));
        sent_cnt++;
    endtask

    // Writes all four registers once the limiter has gone idle.
    task automatic write_limiter_regs(input logic [THRESH_W-1:0] thr,
                                      input logic [COEFF_W-1:0]  atk,
                                      input logic [COEFF_W-1:0]  rel,
                                      input logic [HOLD_W-1:0]   hold);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_ATTACK;
        cfg_data  <= CFG_W'(atk);
        @(posedge clk);
        cfg_index <= CFG_RELEASE;
        cfg_data  <= CFG_W'(rel);
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= CFG_W'(hold);
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_cfg  = thr;
        atk_cfg  = atk;
        rel_cfg  = rel;
        hold_cfg = hold;
        setting_cnt++;
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 17'd65536;
            2:       return COEFF_W'($urandom);
            3:       return COEFF_W'($urandom_range(1, 64));
            default: return COEFF_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic pick_random_setting();
        logic [THRESH_W-1:0] thr;
        logic [HOLD_W-1:0]   hold;
        case ($urandom_range(0, 7))
            0:       thr = 23'd1;
            1:       thr = THRESHOLD_RST;
            2:       thr = THRESH_W'($urandom_range(1, 4096));
            default: thr = THRESH_W'($urandom_range(1, 8388607));
        endcase
        case ($urandom_range(0, 9))
            0:       hold = HOLD_W'($urandom);
            default: hold = HOLD_W'($urandom_range(0, 12));
        endcase
        write_limiter_regs(thr, pick_coeff(), pick_coeff(), hold);
    endtask

    task automatic test_reset_defaults();
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
    endtask

    // Zero coefficients freeze the gain; oversized ones overshoot and clamp.
    task automatic test_coeff_corners();
        write_limiter_regs(23'd4194304, 17'd0, 17'd0, 16'd3);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'd100);
        write_limiter_regs(23'd4194304, 17'h1FFFF, 17'h1FFFF, 16'd0);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        send_sample(24'h800000);
    endtask

    // With no threshold every nonzero sample is pulled to zero gain.
    task automatic test_threshold_zero();
        write_limiter_regs(23'd0, 17'd65536, 17'd65536, 16'd0);
        send_sample(24'h000000);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
    endtask

    task automatic test_hold_extremes();
        write_limiter_regs(23'd1, 17'd32768, 17'd65536, 16'hFFFF);
        send_sample(24'd2);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'h000000);
        send_sample(24'h000001);
    endtask

    // Loud bursts followed by quiet tails, some long enough to outlast the hold.
    task automatic test_envelope();
        int n;
        int loud_len;
        int quiet_len;
        for (int phase = 0; phase < 6; phase++)
        begin
            pick_random_setting();
            n = 0;
            while (n < 90)
            begin
                loud_len  = $urandom_range(1, 8);
                quiet_len = (hold_cfg > 24) ? $urandom_range(0, 30)
                                            : $urandom_range(0, int'(hold_cfg) + 6);
                for (int i = 0; i < loud_len; i++)
                    send_sample(make_sample(SMP_LOUD));
                for (int i = 0; i < quiet_len; i++)
                    send_sample(make_sample(($urandom_range(0, 15) == 0) ? SMP_ANY : SMP_QUIET));
                n += loud_len + quiet_len;
                // Let the output side empty completely once mid-stream.
                if (phase == 2 && n >= 45 && n - loud_len - quiet_len < 45)
                    wait_for_results();
            end
        end
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 3; phase++)
        begin
            pick_random_setting();
            no_idle = (phase == 1);
            for (int i = 0; i < 90; i++)
                send_sample(make_sample(sample_kind_t'($urandom_range(0, 2))));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rx_mode_t mode;
        int mode_left;
        int stall_left;
        mode       = RX_ALWAYS;
        mode_left  = 0;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left == 0 && $urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 30);
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        limit_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (limited_q.size() == 0)
            begin
                $error("unexpected result: out_sample %0d, applied_gain %0d",
                       $signed(out_sample), applied_gain);
                err_cnt++;
            end
            else
            begin
                want = limited_q.pop_front();
                checked_cnt++;
                if (out_sample !== want.out_sample)
                begin
                    $error("out_sample: expected %0d, got %0d",
                           $signed(want.out_sample), $signed(out_sample));
                    err_cnt++;
                end
                if (applied_gain !== want.gain)
                begin
                    $error("applied_gain: expected %0d, got %0d", want.gain, applied_gain);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        thr_cfg    = THRESHOLD_RST;
        atk_cfg    = ATTACK_RST;
        rel_cfg    = RELEASE_RST;
        hold_cfg   = HOLD_RST;
        gain_model = UNITY_GAIN;
        hold_model = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_coeff_corners();
        test_threshold_zero();
        test_hold_extremes();
        test_envelope();
        test_random_mix();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (limited_q.size() != 0)
        begin
            $error("%0d limited samples never came back", limited_q.size());
            err_cnt++;
        end

        $display("Limited %0d samples, %0d results checked, over %0d register settings.",
                 sent_cnt, checked_cnt, setting_cnt);
        $display("Gain updates seen: %0d attack, %0d hold countdown, %0d release.",
                 attack_cnt, holding_cnt, release_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[peak_limiter_with_hold_core.f]
sv/pklim_pkg.sv
sv/pklim_ctrl.sv
sv/pklim_dp.sv
sv/peak_limiter_with_hold_core.sv
bench/tb.sv
